[rtl/core/dfr_pkg.sv]
package dfr_pkg;

  // Parser mode, one-hot
  typedef enum logic [3:0] {
    MODE_IDLE      = 4'b0001,
    MODE_IDLE_ESC  = 4'b0010,
    MODE_FRAME     = 4'b0100,
    MODE_FRAME_ESC = 4'b1000
  } mode_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_END     = 2'd1,
    KIND_ABORT   = 2'd2
  } kind_t;

  // Frame end error codes
  typedef enum logic [1:0] {
    ERR_GOOD     = 2'd0,
    ERR_SHORT    = 2'd1,
    ERR_SUM      = 2'd2,
    ERR_OVERFLOW = 2'd3
  } err_t;

  // Command classes
  typedef enum logic [1:0] {
    CMD_BUS     = 2'd0,
    CMD_GATEWAY = 2'd1,
    CMD_OTHER   = 2'd2
  } cmd_t;

  // Configuration register indexes
  localparam logic [2:0] REG_ESCAPE_CODE  = 3'd0;
  localparam logic [2:0] REG_START_CODE   = 3'd1;
  localparam logic [2:0] REG_END_CODE     = 3'd2;
  localparam logic [2:0] REG_BUS_CMD      = 3'd3;
  localparam logic [2:0] REG_GATEWAY_CMD  = 3'd4;
  localparam logic [2:0] REG_LENIENT      = 3'd5;

  // Frames shorter than this are reported short
  localparam int MIN_GOOD_LEN = 3;

  typedef struct packed {
    logic [7:0] escape_code;
    logic [7:0] start_code;
    logic [7:0] end_code;
    logic [7:0] bus_msg_command;
    logic [7:0] gateway_msg_command;
    logic       escape_lenient;
  } cfg_t;

  // Per-frame state, byte count kept apart since its width is parameterized
  typedef struct packed {
    mode_t      mode;
    logic [7:0] running_sum;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       overflow_flag;
  } frame_state_t;

  typedef struct packed {
    kind_t      out_kind;
    logic [7:0] out_byte;
    logic [8:0] out_index;
    logic [9:0] frame_length;
    err_t       error_code;
    cmd_t       command_kind;
    logic [7:0] command_byte;
    logic [7:0] payload_length;
  } result_t;

endpackage

[rtl/core/dfr_step.sv]
module dfr_step #(
  parameter int MAX_FRAME = 512,
  parameter int CW        = 10
) (
  input  dfr_pkg::cfg_t         cfg,
  input  dfr_pkg::frame_state_t st,
  input  logic [CW-1:0]         cnt,
  input  logic [7:0]            rx_byte,
  output dfr_pkg::frame_state_t st_next,
  output logic [CW-1:0]         cnt_next,
  output logic                  res_valid,
  output dfr_pkg::result_t      res
);
  import dfr_pkg::*;

  logic           do_store;
  logic           do_end;
  logic           do_abort;
  logic           do_clear;
  mode_t          mode_next;
  logic [CW+9:0]  cnt_ext;
  logic           is_esc;
  logic           is_start;
  logic           is_end;

  assign cnt_ext  = {10'd0, cnt};
  assign is_esc   = (rx_byte == cfg.escape_code);
  assign is_start = (rx_byte == cfg.start_code);
  assign is_end   = (rx_byte == cfg.end_code);

  // Mode decode: pick the action for this byte
  always_comb begin
    do_store  = 1'b0;
    do_end    = 1'b0;
    do_abort  = 1'b0;
    do_clear  = 1'b0;
    mode_next = st.mode;
    case (st.mode)
      MODE_IDLE: begin
        if (is_esc) mode_next = MODE_IDLE_ESC;
      end
      MODE_IDLE_ESC: begin
        if (!is_end && is_start) begin
          do_clear  = 1'b1;
          mode_next = MODE_FRAME;
        end else begin
          mode_next = MODE_IDLE;
        end
      end
      MODE_FRAME: begin
        if (is_esc) mode_next = MODE_FRAME_ESC;
        else        do_store  = 1'b1;
      end
      MODE_FRAME_ESC: begin
        if (is_end) begin
          do_end    = 1'b1;
          do_clear  = 1'b1;
          mode_next = MODE_IDLE;
        end else if (is_start) begin
          // restart inside a frame
          do_abort  = 1'b1;
          do_clear  = 1'b1;
          mode_next = MODE_FRAME;
        end else if (is_esc || cfg.escape_lenient) begin
          do_store  = 1'b1;
          mode_next = MODE_FRAME;
        end else begin
          // bad escape
          do_abort  = 1'b1;
          do_clear  = 1'b1;
          mode_next = MODE_IDLE;
        end
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase
  end

  // State update and result build
  always_comb begin
    st_next      = st;
    st_next.mode = mode_next;
    cnt_next     = cnt;
    res_valid    = 1'b0;
    res          = '0;
    res.out_kind     = KIND_PAYLOAD;
    res.error_code   = ERR_GOOD;
    res.command_kind = CMD_BUS;

    if (do_store) begin
      if (cnt >= CW'(MAX_FRAME)) begin
        st_next.overflow_flag = 1'b1;
      end else begin
        if (cnt == '0)           st_next.first_byte  = rx_byte;
        else if (cnt == CW'(1))  st_next.second_byte = rx_byte;
        st_next.running_sum = st.running_sum + rx_byte;
        cnt_next            = cnt + CW'(1);
        res_valid           = 1'b1;
        res.out_kind        = KIND_PAYLOAD;
        res.out_byte        = rx_byte;
        res.out_index       = cnt_ext[8:0];
      end
    end

    if (do_end) begin
      res_valid        = 1'b1;
      res.out_kind     = KIND_END;
      res.frame_length = cnt_ext[9:0];
      if (st.overflow_flag)               res.error_code = ERR_OVERFLOW;
      else if (cnt < CW'(MIN_GOOD_LEN))   res.error_code = ERR_SHORT;
      else if (st.running_sum != 8'd0)    res.error_code = ERR_SUM;
      else                                res.error_code = ERR_GOOD;
      if (st.first_byte == cfg.bus_msg_command)          res.command_kind = CMD_BUS;
      else if (st.first_byte == cfg.gateway_msg_command) res.command_kind = CMD_GATEWAY;
      else                                               res.command_kind = CMD_OTHER;
      res.command_byte   = st.first_byte;
      res.payload_length = st.second_byte;
    end

    if (do_abort) begin
      res_valid    = 1'b1;
      res.out_kind = KIND_ABORT;
    end

    if (do_clear) begin
      cnt_next              = '0;
      st_next.running_sum   = 8'd0;
      st_next.first_byte    = 8'd0;
      st_next.second_byte   = 8'd0;
      st_next.overflow_flag = 1'b0;
    end
  end

endmodule

[rtl/core/dle_frame_receiver_checksum.sv]
// A result appears on the output in the cycle after its byte is accepted.
// Throughput: one byte per cycle; a byte is taken whenever the output register
// is empty or being drained in the same cycle.
// Reset (synchronous, active high): parser idle, frame state cleared, output
// empty, configuration registers back to their default codes.
module dle_frame_receiver_checksum #(
  parameter int MAX_FRAME = 512
) (
  input  logic       clk,
  input  logic       rst,
  // configuration write port
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  // byte input
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  // result output
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [8:0] out_index,
  output logic [9:0] frame_length,
  output logic [1:0] error_code,
  output logic [1:0] command_kind,
  output logic [7:0] command_byte,
  output logic [7:0] payload_length
);
  import dfr_pkg::*;

  localparam int CW = $clog2(MAX_FRAME + 1);

  cfg_t          cfg;
  frame_state_t  st;
  frame_state_t  st_next;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic          res_valid;
  result_t       res_next;
  result_t       res;
  logic          in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.escape_code         <= 8'd16;
      cfg.start_code          <= 8'd2;
      cfg.end_code            <= 8'd3;
      cfg.bus_msg_command     <= 8'd147;
      cfg.gateway_msg_command <= 8'd160;
      cfg.escape_lenient      <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ESCAPE_CODE: cfg.escape_code         <= cfg_data;
        REG_START_CODE:  cfg.start_code          <= cfg_data;
        REG_END_CODE:    cfg.end_code            <= cfg_data;
        REG_BUS_CMD:     cfg.bus_msg_command     <= cfg_data;
        REG_GATEWAY_CMD: cfg.gateway_msg_command <= cfg_data;
        REG_LENIENT:     cfg.escape_lenient      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Per-byte parse step
  dfr_step #(
    .MAX_FRAME (MAX_FRAME),
    .CW        (CW)
  ) u_step (
    .cfg       (cfg),
    .st        (st),
    .cnt       (cnt),
    .rx_byte   (rx_byte),
    .st_next   (st_next),
    .cnt_next  (cnt_next),
    .res_valid (res_valid),
    .res       (res_next)
  );

  // Frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode          <= MODE_IDLE;
      st.running_sum   <= 8'd0;
      st.first_byte    <= 8'd0;
      st.second_byte   <= 8'd0;
      st.overflow_flag <= 1'b0;
      cnt              <= '0;
    end else if (in_fire) begin
      st  <= st_next;
      cnt <= cnt_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      res <= res_next;
    end
  end

  assign out_kind       = res.out_kind;
  assign out_byte       = res.out_byte;
  assign out_index      = res.out_index;
  assign frame_length   = res.frame_length;
  assign error_code     = res.error_code;
  assign command_kind   = res.command_kind;
  assign command_byte   = res.command_byte;
  assign payload_length = res.payload_length;

endmodule
